FILE: rtl/frustum_box_cull_defines.svh
// Assertion macros shared by the frustum box cull RTL.
// No dependencies; files that assert take this header by include.
`ifndef FRUSTUM_BOX_CULL_DEFINES_SVH
`define FRUSTUM_BOX_CULL_DEFINES_SVH
`ifndef SYNTHESIS
// clocked check, masked while rst is high
`define FBC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// clocked check that also runs during reset
`define FBC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FBC_ASSERT(lbl, prop, msg)
`define FBC_ASSERT_RST(lbl, prop, msg)
`endif
`endif

FILE: rtl/fbc_pkg.sv
// Types and fixed widths for the frustum box cull block.
// No dependencies; used by fbc_plane_lane and frustum_box_cull.
package fbc_pkg;

  localparam int NormW   = 18;            // Q1.16 normal component
  localparam int OffsW   = 40;            // Q23.16 plane offset
  localparam int CoordW  = 24;            // integer box coordinate
  localparam int AxisCnt = 3;
  localparam int NormalW = AxisCnt * NormW;
  localparam int ProdW   = NormW + CoordW;  // full product
  localparam int PSumW   = ProdW + 1;       // sum of two terms
  localparam int SumW    = PSumW + 1;       // sum of four terms

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TEST = 1'b1
  } fbc_op_t;

  // per-stage advance strobes for the lane datapath
  typedef struct packed {
    logic s1;   // products
    logic s2;   // per-axis max
    logic s3;   // partial sums
  } fbc_adv_t;

endpackage

FILE: rtl/frustum_box_cull.sv
// Frustum box cull top level: plane table, pipeline control, final verdict.
// Depends on fbc_pkg, fbc_plane_lane and frustum_box_cull_defines.svh.
//
// Tests axis-aligned boxes against a table of PLANE_COUNT planes and takes
// one item per clock while the output is not stalled. A load item
// (opcode 0) writes the plane at plane_index into the table and gives no
// result; an index at or past PLANE_COUNT is dropped. A test item
// (opcode 1) gives one transfer on the output: visible is 0 when some
// plane has all eight box corners strictly behind it, 1 otherwise. Its
// path runs through the input register, the product register, the
// per-axis max register, the partial sum register and the result
// register. Every plane has its own lane of six 18x24 multipliers, so
// throughput is one item a cycle for any plane count when not stalled.
// Loads take effect for every test that follows them in the input order.
// The table is all zero after reset, and a zero plane never culls.
// Stall on the output backs up stage by stage; in_stall rises only when
// the input register is full and cannot move.
`include "frustum_box_cull_defines.svh"

module frustum_box_cull #(
  parameter int PLANE_COUNT = 6
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         opcode,
  input  logic [2:0]                   plane_index,
  input  logic signed [fbc_pkg::NormW-1:0]  normal_x,
  input  logic signed [fbc_pkg::NormW-1:0]  normal_y,
  input  logic signed [fbc_pkg::NormW-1:0]  normal_z,
  input  logic signed [fbc_pkg::OffsW-1:0]  plane_offset,
  input  logic signed [fbc_pkg::CoordW-1:0] box_min_x,
  input  logic signed [fbc_pkg::CoordW-1:0] box_min_y,
  input  logic signed [fbc_pkg::CoordW-1:0] box_min_z,
  input  logic signed [fbc_pkg::CoordW-1:0] box_max_x,
  input  logic signed [fbc_pkg::CoordW-1:0] box_max_y,
  input  logic signed [fbc_pkg::CoordW-1:0] box_max_z,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         visible
);

  // ---------------------------------------------------------------------
  // Plane table: one register row per plane, cleared by reset.
  // Normal packing: x in the low bits, then y, then z.
  // ---------------------------------------------------------------------
  logic [PLANE_COUNT-1:0][fbc_pkg::NormalW-1:0] plane_normals;
  logic [PLANE_COUNT-1:0][fbc_pkg::OffsW-1:0]   plane_offsets;

  // ---------------------------------------------------------------------
  // Stage 0: input register
  // ---------------------------------------------------------------------
  logic                    v0;
  fbc_pkg::fbc_op_t        op0;
  logic [2:0]              idx0;
  logic [fbc_pkg::NormalW-1:0] nrm0;
  logic [fbc_pkg::OffsW-1:0]   offs0;
  logic [fbc_pkg::AxisCnt-1:0][fbc_pkg::CoordW-1:0] lo0;
  logic [fbc_pkg::AxisCnt-1:0][fbc_pkg::CoordW-1:0] hi0;

  // stage valids downstream of the input register
  logic v1, v2, v3;

  // ready/advance chain, computed back from the output register
  logic rdy0, rdy1, rdy2, rdy3, rdy4;
  logic adv1, adv2, adv3, adv4;
  logic accept;
  logic load_go;     // a load leaves stage 0 and writes the table
  logic load_hit;    // that load names a slot that exists

  fbc_pkg::fbc_adv_t lane_adv;

  assign rdy4   = !out_valid || !out_stall;
  assign adv4   = v3 && rdy4;
  assign rdy3   = !v3 || rdy4;
  assign adv3   = v2 && rdy3;
  assign rdy2   = !v2 || rdy3;
  assign adv2   = v1 && rdy2;
  assign rdy1   = !v1 || rdy2;
  assign adv1   = v0 && rdy1;
  assign rdy0   = !v0 || rdy1;
  assign in_stall = !rdy0;
  assign accept   = in_valid && rdy0;

  assign lane_adv.s1 = adv1;
  assign lane_adv.s2 = adv2;
  assign lane_adv.s3 = adv3;

  assign load_go  = adv1 && (op0 == fbc_pkg::OP_LOAD);
  assign load_hit = int'(idx0) < PLANE_COUNT;

  always_ff @(posedge clk) begin
    if (accept) begin
      op0   <= fbc_pkg::fbc_op_t'(opcode);
      idx0  <= plane_index;
      nrm0  <= {normal_z, normal_y, normal_x};
      offs0 <= plane_offset;
      lo0   <= {box_min_z, box_min_y, box_min_x};
      hi0   <= {box_max_z, box_max_y, box_max_x};
    end
  end

  // valid bits: a load drops out after stage 0, it has no result
  always_ff @(posedge clk) begin
    if (rst) begin
      v0        <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        v0 <= 1'b1;
      end else if (adv1) begin
        v0 <= 1'b0;
      end

      if (adv1) begin
        v1 <= (op0 == fbc_pkg::OP_TEST);
      end else if (adv2) begin
        v1 <= 1'b0;
      end

      if (adv2) begin
        v2 <= 1'b1;
      end else if (adv3) begin
        v2 <= 1'b0;
      end

      if (adv3) begin
        v3 <= 1'b1;
      end else if (adv4) begin
        v3 <= 1'b0;
      end

      if (adv4) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Table write happens as the load leaves stage 0, so a test behind it
  // (still in stage 0 or not yet taken) sees the new plane, and a test
  // ahead of it has already captured its products.
  for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_table
    always_ff @(posedge clk) begin
      if (rst) begin
        plane_normals[p] <= '0;
        plane_offsets[p] <= '0;
      end else if (load_go && load_hit && (int'(idx0) == p)) begin
        plane_normals[p] <= nrm0;
        plane_offsets[p] <= offs0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stages 1-3: one lane per plane. Stage 4: verdict register.
  // Max over the eight corners of n.c + d is d plus the larger of the
  // two products on each axis; the box is behind when that max is < 0.
  // ---------------------------------------------------------------------
  logic [PLANE_COUNT-1:0] behind;

  for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_lane
    logic signed [fbc_pkg::PSumW-1:0] sum_a;
    logic signed [fbc_pkg::PSumW-1:0] sum_b;
    logic        [fbc_pkg::SumW-1:0]  total;

    fbc_plane_lane u_lane (
      .clk    (clk),
      .adv    (lane_adv),
      .normal (plane_normals[p]),
      .offset (plane_offsets[p]),
      .box_lo (lo0),
      .box_hi (hi0),
      .sum_a  (sum_a),
      .sum_b  (sum_b)
    );

    assign total = {sum_a[fbc_pkg::PSumW-1], sum_a}
                 + {sum_b[fbc_pkg::PSumW-1], sum_b};
    assign behind[p] = total[fbc_pkg::SumW-1];
  end

  always_ff @(posedge clk) begin
    if (adv4) begin
      visible <= ~|behind;
    end
  end

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  `FBC_ASSERT_RST(a_rst_clears, rst |=> (!out_valid && !v0 && !v1), "valid set after reset")
  `FBC_ASSERT(a_stall_only_full, in_stall |-> v0, "input stalled with empty stage 0")
  `FBC_ASSERT(a_load_no_result, load_go |=> !v1, "load item entered the test pipeline")
  `FBC_ASSERT(a_drop_bad_slot, (load_go && !load_hit) |=> ($stable(plane_normals) && $stable(plane_offsets)), "out of range load changed the table")
  `FBC_ASSERT(a_stage3_to_out, adv4 |=> out_valid, "finished test not presented")

endmodule

FILE: rtl/fbc_plane_lane.sv
// One plane's datapath: products, per-axis max and partial sums.
// Depends on fbc_pkg.
module fbc_plane_lane (
  input  logic                                                   clk,
  input  fbc_pkg::fbc_adv_t                                      adv,
  input  logic [fbc_pkg::NormalW-1:0]                            normal,
  input  logic [fbc_pkg::OffsW-1:0]                              offset,
  input  logic [fbc_pkg::AxisCnt-1:0][fbc_pkg::CoordW-1:0]       box_lo,
  input  logic [fbc_pkg::AxisCnt-1:0][fbc_pkg::CoordW-1:0]       box_hi,
  output logic signed [fbc_pkg::PSumW-1:0]                       sum_a,
  output logic signed [fbc_pkg::PSumW-1:0]                       sum_b
);

  logic signed [fbc_pkg::ProdW-1:0] prod_lo [fbc_pkg::AxisCnt];
  logic signed [fbc_pkg::ProdW-1:0] prod_hi [fbc_pkg::AxisCnt];
  logic signed [fbc_pkg::ProdW-1:0] axis_max [fbc_pkg::AxisCnt];
  logic [fbc_pkg::OffsW-1:0]        offs1;
  logic [fbc_pkg::OffsW-1:0]        offs2;

  for (genvar k = 0; k < fbc_pkg::AxisCnt; k++) begin : g_axis
    logic signed [fbc_pkg::NormW-1:0]  n_k;
    logic signed [fbc_pkg::ProdW-1:0]  lo_p;
    logic signed [fbc_pkg::ProdW-1:0]  hi_p;

    assign n_k  = $signed(normal[k*fbc_pkg::NormW +: fbc_pkg::NormW]);
    assign lo_p = n_k * $signed(box_lo[k]);
    assign hi_p = n_k * $signed(box_hi[k]);

    always_ff @(posedge clk) begin
      if (adv.s1) begin
        prod_lo[k] <= lo_p;
        prod_hi[k] <= hi_p;
      end
      // corner sum is separable: best corner takes the larger term per axis
      if (adv.s2) begin
        axis_max[k] <= (prod_lo[k] > prod_hi[k]) ? prod_lo[k] : prod_hi[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      offs1 <= offset;
    end
    if (adv.s2) begin
      offs2 <= offs1;
    end
    if (adv.s3) begin
      sum_a <= {axis_max[0][fbc_pkg::ProdW-1], axis_max[0]}
             + {axis_max[1][fbc_pkg::ProdW-1], axis_max[1]};
      sum_b <= {axis_max[2][fbc_pkg::ProdW-1], axis_max[2]}
             + {{(fbc_pkg::PSumW-fbc_pkg::OffsW){offs2[fbc_pkg::OffsW-1]}}, offs2};
    end
  end

endmodule
